// ===== hw/rtl/ascl_pkg.sv =====
// ----------------------------------------------------------------------------
// ascl_pkg: shared definitions for the adaptive stop cutoff learner
// Command codes, learning event codes, register map and field widths.
// ----------------------------------------------------------------------------
package ascl_pkg;

	// Field widths
	localparam int WeightW   = 20;
	localparam int TimeW     = 32;
	localparam int TargetW   = 19;
	localparam int GainW     = 16;
	localparam int CountW    = 16;
	localparam int ErrW      = 21;
	localparam int SettleW   = 16;
	localparam int EffW      = 20;
	localparam int CmdW      = 3;
	localparam int EventW    = 2;

	// Stream and register port widths
	localparam int InDataW   = 56;
	localparam int OutDataW  = 88;
	localparam int AddrW     = 5;
	localparam int PDataW    = 32;

	// Register reset values
	localparam logic [TargetW-1:0] TargetRst    = 19'd3600;
	localparam logic [GainW-1:0]   GainRst      = 16'd16384;
	localparam logic [TargetW-1:0] LateRst      = 19'd500;
	localparam logic [TargetW-1:0] EarlyRst     = 19'd1000;
	localparam logic [TargetW-1:0] MaxErrRst    = 19'd1000;
	localparam logic [SettleW-1:0] SettleRst    = 16'd2000;

	// Commands carried on s_tuser
	typedef enum logic [CmdW-1:0] {
		CMD_SAMPLE      = 3'd0,
		CMD_RELAY_ON    = 3'd1,
		CMD_RELAY_OFF   = 3'd2,
		CMD_STATUS      = 3'd3,
		CMD_RESET_LEARN = 3'd4
	} cmd_t;

	// Learning events reported per result
	typedef enum logic [EventW-1:0] {
		EV_NONE   = 2'd0,
		EV_UPDATE = 2'd1,
		EV_REJECT = 2'd2
	} event_t;

	// Register indexes (byte address is 4 * index)
	typedef enum logic [2:0] {
		REG_TARGET    = 3'd0,
		REG_LEARN_EN  = 3'd1,
		REG_CUTOFF_EN = 3'd2,
		REG_GAIN      = 3'd3,
		REG_MAX_LATE  = 3'd4,
		REG_MAX_EARLY = 3'd5,
		REG_MAX_ERR   = 3'd6,
		REG_SETTLE    = 3'd7
	} reg_idx_t;

endpackage

// ===== hw/rtl/adaptive_stop_cutoff_learner.sv =====
// ----------------------------------------------------------------------------
// adaptive_stop_cutoff_learner: weight-triggered cutoff with a learned offset
// Cuts when an armed weight sample reaches the effective setpoint, then learns
// the stop offset from the settled weight.
// ----------------------------------------------------------------------------
//
// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready  tuser command, tdata weight/relay/time
// m_*       out  m_tvalid/m_tready  tdata status and learning result
// apb       in   psel/penable       8 registers at 4*i, pready always high
//
// One result per input beat; a beat may enter every cycle while m_tready is high.
// The path has two registers: an input register (error and gain product formed on
// entry) and a result register, with the state update in between.
// A stalled m_tready holds the result register; the input register still
// takes one more beat, then s_tready drops until the result is taken.
// arst_n clears control state and loads the register reset values.

module adaptive_stop_cutoff_learner (
	input  logic                          clk,
	input  logic                          arst_n,
	// Input stream
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// [55:0]: weight [19:0], remote_relay_on [20], time_ms [52:21], zero pad
	input  logic [ascl_pkg::InDataW-1:0]  s_tdata,
	// [2:0]: command
	input  logic [ascl_pkg::CmdW-1:0]     s_tuser,
	// Result stream
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// [87:0]: cut_now [0], effective_target [20:1], offset_out [40:21],
	// observation_count [56:41], final_error [77:57], learn_event [79:78],
	// observing [80], zero pad
	output logic [ascl_pkg::OutDataW-1:0] m_tdata,
	// Register port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ascl_pkg::AddrW-1:0]    paddr,
	input  logic [ascl_pkg::PDataW-1:0]   pwdata,
	output logic [ascl_pkg::PDataW-1:0]   prdata,
	output logic                          pready
);
	import ascl_pkg::*;

	localparam int ProdW = ErrW + GainW + 1;
	localparam int WideW = EffW + 2;

	// Registers
	logic [TargetW-1:0] target_q;
	logic               learn_en_q;
	logic               cutoff_en_q;
	logic [GainW-1:0]   gain_q;
	logic [TargetW-1:0] max_late_q;
	logic [TargetW-1:0] max_early_q;
	logic [TargetW-1:0] max_err_q;
	logic [SettleW-1:0] settle_q;

	// Learner state
	logic signed [WeightW-1:0] offset_q;
	logic [CountW-1:0]         obs_cnt_q;
	logic                      awaiting_q;
	logic [TimeW-1:0]          cut_time_q;
	logic signed [ErrW-1:0]    last_err_q;
	logic                      armed_q;
	logic                      cut_done_q;
	logic                      suppress_q;
	logic                      remote_on_q;

	// Input stage
	logic                      valid_s1;
	cmd_t                      cmd_s1;
	logic signed [WeightW-1:0] weight_s1;
	logic                      relay_s1;
	logic [TimeW-1:0]          time_s1;
	logic signed [ErrW-1:0]    err_s1;
	logic signed [ErrW-1:0]    delta_s1;

	// Result stage
	logic                      valid_s2;
	logic [OutDataW-1:0]       data_s2;

	// Handshake
	logic in_acc;
	logic ld_s2;
	logic cfg_wr;
	reg_idx_t cfg_idx;

	// Entry arithmetic
	logic signed [WeightW-1:0] in_weight;
	logic signed [ErrW-1:0]    in_err;
	logic signed [ProdW-1:0]   in_prod;

	// Next state
	logic signed [WeightW-1:0] offset_n;
	logic [CountW-1:0]         obs_cnt_n;
	logic                      awaiting_n;
	logic [TimeW-1:0]          cut_time_n;
	logic signed [ErrW-1:0]    last_err_n;
	logic                      armed_n;
	logic                      cut_done_n;
	logic                      suppress_n;
	logic                      remote_on_n;
	logic                      cut_n;
	event_t                    ev_n;
	logic [EffW-1:0]           eff_n;

	logic [TimeW-1:0]          elapsed;
	logic                      obs_due;
	logic [ErrW-1:0]           err_mag;
	logic                      reject;
	logic signed [WideW-1:0]   off_sum;
	logic signed [WideW-1:0]   off_lo;
	logic signed [WideW-1:0]   off_hi;
	logic                      may_observe;

	// Effective setpoint: target minus offset when learning is on, clamped to [0, target + late]
	function automatic logic [EffW-1:0] eff_calc(
		input logic [TargetW-1:0]        t,
		input logic                      en,
		input logic [TargetW-1:0]        late,
		input logic signed [WeightW-1:0] off
	);
		logic signed [WideW-1:0] e;
		logic signed [WideW-1:0] hi;
		e  = $signed({3'b000, t});
		hi = $signed({3'b000, t} + {3'b000, late});
		if (en) begin
			e = e - WideW'(off);
		end
		if (e < 0) begin
			e = '0;
		end else if (e > hi) begin
			e = hi;
		end
		return e[EffW-1:0];
	endfunction

	// Stream handshake
	assign ld_s2    = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || ld_s2;
	assign in_acc   = s_tvalid && s_tready;
	assign m_tvalid = valid_s2;
	assign m_tdata  = data_s2;

	// Register port
	assign pready  = 1'b1;
	assign cfg_idx = reg_idx_t'(paddr[AddrW-1:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_comb begin
		case (cfg_idx)
			REG_TARGET:    prdata = PDataW'(target_q);
			REG_LEARN_EN:  prdata = PDataW'(learn_en_q);
			REG_CUTOFF_EN: prdata = PDataW'(cutoff_en_q);
			REG_GAIN:      prdata = PDataW'(gain_q);
			REG_MAX_LATE:  prdata = PDataW'(max_late_q);
			REG_MAX_EARLY: prdata = PDataW'(max_early_q);
			REG_MAX_ERR:   prdata = PDataW'(max_err_q);
			REG_SETTLE:    prdata = PDataW'(settle_q);
			default:       prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q    <= TargetRst;
			learn_en_q  <= 1'b1;
			cutoff_en_q <= 1'b0;
			gain_q      <= GainRst;
			max_late_q  <= LateRst;
			max_early_q <= EarlyRst;
			max_err_q   <= MaxErrRst;
			settle_q    <= SettleRst;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_TARGET:    target_q    <= pwdata[TargetW-1:0];
				REG_LEARN_EN:  learn_en_q  <= pwdata[0];
				REG_CUTOFF_EN: cutoff_en_q <= pwdata[0];
				REG_GAIN:      gain_q      <= pwdata[GainW-1:0];
				REG_MAX_LATE:  max_late_q  <= pwdata[TargetW-1:0];
				REG_MAX_EARLY: max_early_q <= pwdata[TargetW-1:0];
				REG_MAX_ERR:   max_err_q   <= pwdata[TargetW-1:0];
				REG_SETTLE:    settle_q    <= pwdata[SettleW-1:0];
				default: ;
			endcase
		end
	end

	// Form error and scaled correction on entry; floor shift is a bit-select
	assign in_weight = $signed(s_tdata[WeightW-1:0]);
	assign in_err    = ErrW'(in_weight) - $signed({2'b00, target_q});
	assign in_prod   = ProdW'(in_err) * $signed({{(ProdW-GainW){1'b0}}, gain_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// Hold the input beat
	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_s1    <= cmd_t'(s_tuser);
			weight_s1 <= in_weight;
			relay_s1  <= s_tdata[WeightW];
			time_s1   <= s_tdata[WeightW+TimeW:WeightW+1];
			err_s1    <= in_err;
			delta_s1  <= in_prod[GainW+ErrW-1:GainW];
		end
	end

	// Observation bookkeeping
	assign elapsed     = time_s1 - cut_time_q;
	assign obs_due     = awaiting_q && (elapsed >= TimeW'(settle_q));
	assign err_mag     = err_s1[ErrW-1] ? ErrW'(-err_s1) : ErrW'(err_s1);
	assign reject      = (err_mag > ErrW'(max_err_q)) || weight_s1[WeightW-1]
	                     || (target_q == '0);
	assign off_sum     = WideW'(offset_q) + WideW'(delta_s1);
	assign off_lo      = -$signed({3'b000, max_late_q});
	assign off_hi      = $signed({3'b000, max_early_q});
	assign may_observe = learn_en_q && (target_q != '0);

	// Apply one command to the learner state
	always_comb begin
		offset_n    = offset_q;
		obs_cnt_n   = obs_cnt_q;
		awaiting_n  = awaiting_q;
		cut_time_n  = cut_time_q;
		last_err_n  = last_err_q;
		armed_n     = armed_q;
		cut_done_n  = cut_done_q;
		suppress_n  = suppress_q;
		remote_on_n = remote_on_q;
		cut_n       = 1'b0;
		ev_n        = EV_NONE;
		case (cmd_s1)
			CMD_SAMPLE: begin
				// Close a due observation first
				if (obs_due) begin
					awaiting_n = 1'b0;
					last_err_n = err_s1;
					if (reject) begin
						ev_n = EV_REJECT;
					end else begin
						ev_n = EV_UPDATE;
						if (off_sum < off_lo) begin
							offset_n = WeightW'(off_lo);
						end else if (off_sum > off_hi) begin
							offset_n = WeightW'(off_hi);
						end else begin
							offset_n = WeightW'(off_sum);
						end
						if (obs_cnt_q != '1) begin
							obs_cnt_n = obs_cnt_q + 1'b1;
						end
					end
				end
				// Then check the cut against the updated setpoint
				if (cutoff_en_q && armed_q && !cut_done_q
				    && ($signed({{2{weight_s1[WeightW-1]}}, weight_s1})
				        >= $signed({2'b00, eff_calc(target_q, learn_en_q,
				                                    max_late_q, offset_n)}))) begin
					cut_done_n = 1'b1;
					armed_n    = 1'b0;
					cut_n      = 1'b1;
					if (may_observe) begin
						awaiting_n = 1'b1;
						cut_time_n = time_s1;
					end
				end
			end
			CMD_RELAY_ON: begin
				awaiting_n = 1'b0;
				suppress_n = 1'b0;
				if (cutoff_en_q) begin
					armed_n    = 1'b1;
					cut_done_n = 1'b0;
				end
			end
			CMD_RELAY_OFF: begin
				awaiting_n = 1'b0;
				suppress_n = 1'b1;
				if (cutoff_en_q) begin
					armed_n = 1'b0;
				end
			end
			CMD_STATUS: begin
				remote_on_n = relay_s1;
				// Remote on-to-off edge: consume our own stop, else observe
				if (remote_on_q && !relay_s1) begin
					if (suppress_q) begin
						suppress_n = 1'b0;
					end else if (!awaiting_q && may_observe) begin
						awaiting_n = 1'b1;
						cut_time_n = time_s1;
					end
				end
			end
			CMD_RESET_LEARN: begin
				offset_n   = '0;
				obs_cnt_n  = '0;
				last_err_n = '0;
				awaiting_n = 1'b0;
			end
			default: ;
		endcase
		eff_n = eff_calc(target_q, learn_en_q, max_late_q, offset_n);
	end

	// Advance state on each result, apply register side effects when idle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q    <= '0;
			obs_cnt_q   <= '0;
			awaiting_q  <= 1'b0;
			cut_time_q  <= '0;
			last_err_q  <= '0;
			armed_q     <= 1'b0;
			cut_done_q  <= 1'b0;
			suppress_q  <= 1'b0;
			remote_on_q <= 1'b0;
		end else if (ld_s2) begin
			offset_q    <= offset_n;
			obs_cnt_q   <= obs_cnt_n;
			awaiting_q  <= awaiting_n;
			cut_time_q  <= cut_time_n;
			last_err_q  <= last_err_n;
			armed_q     <= armed_n;
			cut_done_q  <= cut_done_n;
			suppress_q  <= suppress_n;
			remote_on_q <= remote_on_n;
		end else if (cfg_wr && (cfg_idx == REG_LEARN_EN)) begin
			awaiting_q <= 1'b0;
		end else if (cfg_wr && (cfg_idx == REG_CUTOFF_EN)) begin
			armed_q    <= 1'b0;
			cut_done_q <= 1'b0;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ld_s2) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s2) begin
			data_s2 <= {7'b0, awaiting_n, ev_n, last_err_n, obs_cnt_n,
			            offset_n, eff_n, cut_n};
		end
	end

`ifndef NO_ASSERTIONS
	// A cut with learning on and a nonzero target starts an observation
	a_cut_observes: assert property (@(posedge clk) disable iff (!arst_n)
		ld_s2 && cut_n && may_observe |=> awaiting_q)
		else $error("cut did not start an observation");

	// Armed and cut-done are never set together
	a_arm_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(armed_q && cut_done_q))
		else $error("armed and cut_done both set");

	// The observation count moves only with a result
	a_cnt_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!ld_s2 |=> $stable(obs_cnt_q))
		else $error("observation count changed without a result");

	// Input backpressure only while both the input and result registers are occupied
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> valid_s1 && valid_s2)
		else $error("input stalled with room available");
`endif

endmodule
